[rtl/kmpss_pkg.sv]
`default_nettype none
package kmpss_pkg;

	localparam int unsigned MAX_PATTERN_DEF    = 64;
	localparam int unsigned POSITION_WIDTH_DEF = 32;

	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	typedef enum logic [1:0] {
		STAT_BUSY,
		STAT_FOUND,
		STAT_NOTFOUND,
		STAT_OVERFLOW
	} stat_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_DECODE,
		CS_LOOK,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic look;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic dec_look;
		logic look_fin;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/kmp_substring_search_core.sv]
`default_nettype none
// KMP substring search core.
// Input stream: one request per byte. s_tuser[0] selects pattern append (0) or
// text byte (1), s_tuser[1] restarts the pattern load or starts a new search,
// s_tlast marks the final text byte of a search, s_tdata is the byte.
// Output stream: exactly one result per request. m_tdata[1:0] is the status
// (busy, found, not found, pattern overflow), m_tdata[33:2] the start position
// of the first match when found, zero otherwise.
// Timing: a request is decoded in the cycle after it is taken, then the
// failure-table walk reads pattern and table memories once per cycle, one
// fallback step per cycle. The next request is taken in the same cycle as
// the previous result moves into the output register.
// Reset clears the pattern length, the search state and the output valid;
// pattern and table memories are not cleared and need no sweep.
// If m_tready is held low the result waits in the output register; one more
// request is processed and then held until the output register frees.
module kmp_substring_search_core #(
	parameter int unsigned MAX_PATTERN    = kmpss_pkg::MAX_PATTERN_DEF,
	parameter int unsigned POSITION_WIDTH = kmpss_pkg::POSITION_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // data_byte
	input  wire logic [1:0]  s_tuser,  // func, first
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // status[1:0], match_position[33:2], zero pad
);

	kmpss_pkg::dp_cmd_t  dp_cmd;
	kmpss_pkg::dp_stat_t dp_stat;
	kmpss_pkg::stat_t    out_status;
	logic [31:0]         out_position;

	kmpss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	kmpss_dpath #(
		.MAX_PATTERN    (MAX_PATTERN),
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_func      (s_tuser[0]),
		.in_byte      (s_tdata),
		.in_first     (s_tuser[1]),
		.in_last      (s_tlast),
		.dp_cmd       (dp_cmd),
		.dp_stat      (dp_stat),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_status   (out_status),
		.out_position (out_position)
	);

	assign m_tdata = {6'b0, out_position, out_status};

	a_pos_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != kmpss_pkg::STAT_FOUND) |-> (m_tdata[33:2] == 32'd0))
		else $error("position set on a result that is not found");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous one is in decode");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

endmodule
`default_nettype wire

[rtl/kmpss_ctrl.sv]
`default_nettype none
module kmpss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire kmpss_pkg::dp_stat_t dp_stat,
	output kmpss_pkg::dp_cmd_t       dp_cmd
);

	kmpss_pkg::ctrl_state_t state_q;
	kmpss_pkg::ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmpss_pkg::CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		dp_cmd    = '0;
		unique case (state_q)
			kmpss_pkg::CS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dp_cmd.load = 1'b1;
					state_nxt   = kmpss_pkg::CS_DECODE;
				end
			end
			kmpss_pkg::CS_DECODE: begin
				dp_cmd.decode = 1'b1;
				state_nxt     = dp_stat.dec_look ? kmpss_pkg::CS_LOOK : kmpss_pkg::CS_DONE;
			end
			kmpss_pkg::CS_LOOK: begin
				dp_cmd.look = 1'b1;
				if (dp_stat.look_fin) begin
					state_nxt = kmpss_pkg::CS_DONE;
				end
			end
			kmpss_pkg::CS_DONE: begin
				if (dp_stat.out_free) begin
					dp_cmd.out_load = 1'b1;
					s_tready        = 1'b1;
					if (s_tvalid) begin
						dp_cmd.load = 1'b1;
						state_nxt   = kmpss_pkg::CS_DECODE;
					end else begin
						state_nxt = kmpss_pkg::CS_IDLE;
					end
				end
			end
			default: begin
				state_nxt = kmpss_pkg::CS_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/kmpss_dpath.sv]
`default_nettype none
module kmpss_dpath #(
	parameter int unsigned MAX_PATTERN    = kmpss_pkg::MAX_PATTERN_DEF,
	parameter int unsigned POSITION_WIDTH = kmpss_pkg::POSITION_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_func,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_first,
	input  wire logic               in_last,
	input  wire kmpss_pkg::dp_cmd_t dp_cmd,
	output kmpss_pkg::dp_stat_t     dp_stat,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output kmpss_pkg::stat_t        out_status,
	output logic [31:0]             out_position
);

	localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned JW = LW + 1;
	localparam int unsigned PW = POSITION_WIDTH;

	// pattern and failure table, one read and one write port each
	logic [7:0]    ps_mem [MAX_PATTERN];
	logic [JW-1:0] ft_mem [MAX_PATTERN];
	logic [7:0]    ps_rd_q;
	logic [JW-1:0] ft_rd_q;

	logic          func_q;
	logic [7:0]    byte_q;
	logic          first_q;
	logic          last_q;

	logic [LW-1:0] len_q;
	logic [JW-1:0] bf_q;
	logic [LW-1:0] mc_q;
	logic [PW-1:0] tp_q;
	kmpss_pkg::stat_t sstat_q;
	logic [PW-1:0] held_q;
	logic [7:0]    prev_q;
	logic [AW-1:0] j_q;

	kmpss_pkg::stat_t res_stat_q;
	logic [PW-1:0] res_pos_q;
	logic          out_valid_q;
	kmpss_pkg::stat_t out_stat_q;
	logic [PW-1:0] out_pos_q;

	logic [LW-1:0] n_e;
	logic [LW-1:0] mc_e;
	logic [PW-1:0] tp_e;
	kmpss_pkg::stat_t st_e;
	logic [PW-1:0] held_e;
	logic [LW-1:0] lenm1;
	logic [LW-1:0] j0;
	logic          n_full;
	logic          hit;
	logic          look_fin;
	logic [LW-1:0] k_look;
	logic [PW-1:0] tpn;
	logic [PW+LW-1:0] dif;
	logic [AW-1:0] rd_addr;
	logic          ps_we;
	logic          ft_we;
	logic [AW-1:0] ft_waddr;
	logic [JW-1:0] ft_wdata;
	logic [PW+31:0] pos_ext;

	always_comb begin
		n_e      = first_q ? '0 : len_q;
		n_full   = (n_e >= LW'(MAX_PATTERN));
		mc_e     = first_q ? '0 : mc_q;
		tp_e     = first_q ? '0 : tp_q;
		st_e     = first_q ? kmpss_pkg::STAT_BUSY : sstat_q;
		held_e   = first_q ? '0 : held_q;
		lenm1    = len_q - LW'(1);
		j0       = (mc_e > lenm1) ? lenm1 : mc_e;
		hit      = (ps_rd_q == ((func_q == kmpss_pkg::FUNC_TEXT) ? byte_q : prev_q));
		look_fin = hit || ft_rd_q[JW-1];
		k_look   = hit ? (LW'(j_q) + LW'(1)) : '0;
		tpn      = tp_q + PW'(1);
		dif      = (PW+LW)'(tpn) - (PW+LW)'(len_q);

		if (func_q == kmpss_pkg::FUNC_TEXT) begin
			dp_stat.dec_look = (st_e == kmpss_pkg::STAT_BUSY) && (len_q != '0);
		end else begin
			dp_stat.dec_look = (n_e != '0) && !n_full && !bf_q[JW-1];
		end
		dp_stat.look_fin = look_fin;
		dp_stat.out_free = !out_valid_q || out_ready;

		if (dp_cmd.decode) begin
			rd_addr = (func_q == kmpss_pkg::FUNC_TEXT) ? j0[AW-1:0] : bf_q[AW-1:0];
		end else begin
			rd_addr = ft_rd_q[AW-1:0];
		end

		ps_we = dp_cmd.decode && (func_q == kmpss_pkg::FUNC_PATTERN) && !n_full;
		if (dp_cmd.decode) begin
			ft_we    = ps_we && ((n_e == '0) || bf_q[JW-1]);
			ft_waddr = n_e[AW-1:0];
			ft_wdata = (n_e == '0) ? '1 : '0;
		end else begin
			ft_we    = dp_cmd.look && look_fin && (func_q == kmpss_pkg::FUNC_PATTERN);
			ft_waddr = len_q[AW-1:0];
			ft_wdata = JW'(k_look);
		end

		pos_ext = (PW+32)'(out_pos_q);
	end

	always_ff @(posedge clk) begin
		ps_rd_q <= ps_mem[rd_addr];
		ft_rd_q <= ft_mem[rd_addr];
		if (ps_we) begin
			ps_mem[n_e[AW-1:0]] <= byte_q;
		end
		if (ft_we) begin
			ft_mem[ft_waddr] <= ft_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			func_q  <= in_func;
			byte_q  <= in_byte;
			first_q <= in_first;
			last_q  <= in_last;
		end
		if (dp_cmd.out_load) begin
			out_stat_q <= res_stat_q;
			out_pos_q  <= res_pos_q;
		end
		if (dp_cmd.decode) begin
			if (func_q == kmpss_pkg::FUNC_PATTERN) begin
				res_pos_q <= '0;
				if (n_full) begin
					res_stat_q <= kmpss_pkg::STAT_OVERFLOW;
				end else begin
					res_stat_q <= kmpss_pkg::STAT_BUSY;
					j_q        <= bf_q[AW-1:0];
					if ((n_e == '0) || bf_q[JW-1]) begin
						prev_q <= byte_q;
					end
				end
			end else begin
				j_q <= j0[AW-1:0];
				if (st_e != kmpss_pkg::STAT_BUSY) begin
					res_stat_q <= st_e;
					res_pos_q  <= (st_e == kmpss_pkg::STAT_FOUND) ? held_e : '0;
				end else begin
					res_stat_q <= kmpss_pkg::STAT_FOUND;
					res_pos_q  <= tp_e;
				end
			end
		end
		if (dp_cmd.look) begin
			if (!look_fin) begin
				j_q <= ft_rd_q[AW-1:0];
			end else if (func_q == kmpss_pkg::FUNC_PATTERN) begin
				prev_q     <= byte_q;
				res_stat_q <= kmpss_pkg::STAT_BUSY;
				res_pos_q  <= '0;
			end else if (k_look >= len_q) begin
				res_stat_q <= kmpss_pkg::STAT_FOUND;
				res_pos_q  <= dif[PW-1:0];
			end else if (last_q) begin
				res_stat_q <= kmpss_pkg::STAT_NOTFOUND;
				res_pos_q  <= '0;
			end else begin
				res_stat_q <= kmpss_pkg::STAT_BUSY;
				res_pos_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			bf_q        <= '1;
			mc_q        <= '0;
			tp_q        <= '0;
			sstat_q     <= kmpss_pkg::STAT_BUSY;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (dp_cmd.decode) begin
				if (func_q == kmpss_pkg::FUNC_PATTERN) begin
					mc_q    <= '0;
					tp_q    <= '0;
					sstat_q <= kmpss_pkg::STAT_BUSY;
					held_q  <= '0;
					if (n_full) begin
						len_q <= n_e;
					end else if (n_e == '0) begin
						len_q <= LW'(1);
						bf_q  <= '1;
					end else if (bf_q[JW-1]) begin
						len_q <= n_e + LW'(1);
						bf_q  <= '0;
					end else begin
						len_q <= n_e;
					end
				end else begin
					mc_q    <= mc_e;
					tp_q    <= tp_e;
					sstat_q <= st_e;
					held_q  <= held_e;
					if ((st_e == kmpss_pkg::STAT_BUSY) && (len_q == '0)) begin
						sstat_q <= kmpss_pkg::STAT_FOUND;
						held_q  <= tp_e;
					end
				end
			end
			if (dp_cmd.look && look_fin) begin
				if (func_q == kmpss_pkg::FUNC_PATTERN) begin
					len_q <= len_q + LW'(1);
					bf_q  <= JW'(k_look);
				end else begin
					mc_q <= k_look;
					tp_q <= tpn;
					if (k_look >= len_q) begin
						sstat_q <= kmpss_pkg::STAT_FOUND;
						held_q  <= dif[PW-1:0];
					end else if (last_q) begin
						sstat_q <= kmpss_pkg::STAT_NOTFOUND;
						held_q  <= '0;
					end
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_status   = out_stat_q;
	assign out_position = pos_ext[31:0];

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kmpss_pkg::*;

	localparam int MAX_PAT      = MAX_PATTERN_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 280;
	localparam int SETTLE_CYCLES = 100;

	class kmp_search_scoreboard;
		typedef struct {
			stat_t       status;
			logic [31:0] pos;
		} search_result_t;

		logic [7:0]     pat[MAX_PAT];
		int             fail_tab[MAX_PAT];
		int             pat_len;
		int             build_fb;
		int             match_cnt;
		logic [31:0]    text_pos;
		stat_t          srch_stat;
		logic [31:0]    held_pos;
		search_result_t pending_results[$];
		int             errors;
		int             n_req;
		int             n_checked;
		int             n_found;
		int             n_notfound;
		int             n_overflow;
		int             n_busy;

		function new();
			pat_len = 0;
			build_fb = -1;
			restart_search();
		endfunction

		function void restart_search();
			match_cnt = 0;
			text_pos = '0;
			srch_stat = STAT_BUSY;
			held_pos = '0;
		endfunction

		// returns 0 when a finished search simply replays its held result
		function bit note_request(bit func, logic [7:0] c, bit first, bit last);
			search_result_t r;
			int n;
			int j;
			bit live;
			live = 1'b1;
			r.pos = '0;
			if (func == FUNC_PATTERN) begin
				if (first) begin
					pat_len = 0;
					build_fb = -1;
				end
				restart_search();
				n = pat_len;
				if (n >= MAX_PAT) begin
					r.status = STAT_OVERFLOW;
				end else begin
					pat[n] = c;
					if (n == 0) begin
						fail_tab[0] = -1;
						build_fb = -1;
					end else begin
						j = build_fb;
						while (j != -1 && pat[j] != pat[n-1])
							j = fail_tab[j];
						j++;
						fail_tab[n] = j;
						build_fb = j;
					end
					pat_len = n + 1;
					r.status = STAT_BUSY;
				end
			end else begin
				if (first)
					restart_search();
				if (srch_stat != STAT_BUSY) begin
					live = 1'b0;
				end else if (pat_len == 0) begin
					srch_stat = STAT_FOUND;
					held_pos = text_pos;
				end else begin
					j = (match_cnt > pat_len - 1) ? pat_len - 1 : match_cnt;
					while (j != -1 && pat[j] != c)
						j = fail_tab[j];
					j++;
					match_cnt = j;
					text_pos = text_pos + 32'd1;
					if (j >= pat_len) begin
						srch_stat = STAT_FOUND;
						held_pos = text_pos - 32'(pat_len);
					end else if (last) begin
						srch_stat = STAT_NOTFOUND;
						held_pos = '0;
					end
				end
				r.status = srch_stat;
				if (srch_stat == STAT_FOUND)
					r.pos = held_pos;
			end
			pending_results.push_back(r);
			n_req++;
			return live;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [39:0] word);
			search_result_t want;
			logic [1:0]     got_st;
			logic [31:0]    got_pos;
			got_st = word[1:0];
			got_pos = word[33:2];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with none pending: status=%0d pos=%0d",
					got_st, got_pos));
				return;
			end
			want = pending_results.pop_front();
			n_checked++;
			case (want.status)
				STAT_FOUND:    n_found++;
				STAT_NOTFOUND: n_notfound++;
				STAT_OVERFLOW: n_overflow++;
				default:       n_busy++;
			endcase
			if (got_st !== want.status)
				report_mismatch($sformatf("result %0d: status %0d, want %s",
					n_checked, got_st, want.status.name()));
			if (got_pos !== want.pos)
				report_mismatch($sformatf("result %0d: position %0d, want %0d",
					n_checked, got_pos, want.pos));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte
	logic [1:0]  s_tuser;   // func, first
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // status[1:0], match_position[33:2], zero pad

	kmp_search_scoreboard sb;
	int cycles;
	int consumed;
	int src_idle_pct;
	int snk_stall_pct;
	int alpha_base;
	int alpha_k;
	int n_jobs;

	kmp_substring_search_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles,
				sb.pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_req(bit func, logic [7:0] data, bit first, bit last);
		if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= {first, func};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		void'(sb.note_request(func, data, first, last));
		consumed++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		return 8'(alpha_base + $urandom_range(0, alpha_k - 1));
	endfunction

	// pattern load + a few searches, or 1-4 random requests; some lack first or last
	task automatic run_job(bit force_long);
		int  plen;
		int  tlen;
		int  broken;
		bit  extend;
		n_jobs++;
		if (!force_long && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4))
				send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			return;
		end
		extend = !force_long && ($urandom_range(0, 9) == 0);
		if (!extend) begin
			if ($urandom_range(0, 6) == 0) begin
				alpha_k = 256;
				alpha_base = 0;
			end else begin
				alpha_k = $urandom_range(1, 4);
				alpha_base = $urandom_range(0, 256 - alpha_k);
			end
		end
		if (force_long)
			plen = MAX_PAT + 2;
		else if ($urandom_range(0, 24) == 0)
			plen = $urandom_range(40, MAX_PAT + 2);
		else
			plen = $urandom_range(1, 6);
		for (int i = 0; i < plen; i++)
			send_req(FUNC_PATTERN, pick_byte(), (i == 0) && !extend,
				1'($urandom_range(0, 1)));
		repeat ($urandom_range(1, 3)) begin
			tlen = (plen > 20) ? $urandom_range(10, 70) : $urandom_range(1, 24);
			broken = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
			for (int i = 0; i < tlen; i++)
				send_req(FUNC_TEXT, pick_byte(), (i == 0) && (broken != 1),
					(i == tlen - 1) && (broken != 2));
		end
	endtask

	task automatic run_phase(int src_pct, int snk_pct);
		int target;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		target = consumed + PHASE_ITEMS;
		run_job(1'b1);
		while (consumed < target)
			run_job(1'b0);
		drain();
	endtask

	initial begin
		sb = new();
		cycles = 0;
		consumed = 0;
		n_jobs = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		alpha_base = 0;
		alpha_k = 1;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern: found at once, then held
		send_req(FUNC_TEXT,    8'h5A, 1'b1, 1'b0);
		send_req(FUNC_TEXT,    8'hA5, 1'b0, 1'b1);
		// extremes, match completing on the last byte, held found and not found
		send_req(FUNC_PATTERN, 8'h00, 1'b1, 1'b0);
		send_req(FUNC_PATTERN, 8'hFF, 1'b0, 1'b0);
		send_req(FUNC_PATTERN, 8'h00, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'hFF, 1'b1, 1'b0);
		send_req(FUNC_TEXT,    8'h00, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'hFF, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h00, 1'b0, 1'b1);
		send_req(FUNC_TEXT,    8'h00, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h00, 1'b1, 1'b1);
		send_req(FUNC_TEXT,    8'hFF, 1'b0, 1'b0);
		// self-overlapping pattern forces a fallback
		send_req(FUNC_PATTERN, 8'h41, 1'b1, 1'b1);
		send_req(FUNC_PATTERN, 8'h41, 1'b0, 1'b0);
		send_req(FUNC_PATTERN, 8'h42, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b1, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h42, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h43, 1'b0, 1'b1);
		// pattern append mid-search resets the search
		send_req(FUNC_TEXT,    8'h42, 1'b1, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b0, 1'b0);
		send_req(FUNC_PATTERN, 8'h43, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b1, 1'b0);
		send_req(FUNC_TEXT,    8'h41, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h42, 1'b0, 1'b0);
		send_req(FUNC_TEXT,    8'h43, 1'b0, 1'b1);
		drain();

		run_phase(0, 0);
		run_phase(77, 0);
		run_phase(0, 77);
		run_phase(13, 13);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.pending_results.size()));

		$display("Ran %0d requests (%0d random jobs) under no idling, sender gaps, "
			, sb.n_req, n_jobs, "receiver stalls and both");
		$display("Results: %0d found, %0d not found, %0d overflow, %0d busy; %0d mismatches",
			sb.n_found, sb.n_notfound, sb.n_overflow, sb.n_busy, sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
